// ===== hdl/psc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg
// Shared constants and types for the point seek PD controller.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int unsigned SettleTicks = 10;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned NumSteps    = (CordicSteps < 24) ? CordicSteps : 24;
  localparam int unsigned StepW       = $clog2(NumSteps + 1);
  localparam int unsigned CntW        = 4;

  localparam logic [16:0] SpeedOne = 17'd65536;
  localparam logic [15:0] Ang3Deg  = 16'd546;
  localparam logic [15:0] Ang1p5   = 16'd273;
  localparam logic [23:0] PosTol   = 24'd256;
  localparam logic [16:0] ScaleMin = 17'd13107;

  localparam logic [13:0] KpDist = 14'd13107;
  localparam logic [13:0] KdDist = 14'd7864;
  localparam logic [13:0] KpHead = 14'd3539;
  localparam logic [13:0] KdHead = 14'd7238;
  localparam logic [29:0] CordicGain = 30'd652032874;

  localparam logic [1:0] StatRun     = 2'd0;
  localparam logic [1:0] StatSettled = 2'd1;
  localparam logic [1:0] StatTimeout = 2'd2;

  localparam logic [0:0] OpStart = 1'b0;

  localparam logic [2:0] RegTargetX  = 3'd0;
  localparam logic [2:0] RegTargetY  = 3'd1;
  localparam logic [2:0] RegTargetHd = 3'd2;
  localparam logic [2:0] RegMaxMove  = 3'd3;
  localparam logic [2:0] RegMaxRot   = 3'd4;
  localparam logic [2:0] RegTimeout  = 3'd5;

  typedef struct packed {
    logic        op;
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [15:0] heading;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] bearing;
    logic [16:0] move_speed;
    logic [16:0] rot_speed;
    logic [1:0]  status;
  } out_beat_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0: atan_lut = 32'h20000000;  5'd1: atan_lut = 32'h12E4051E;
      5'd2: atan_lut = 32'h09FB385B;  5'd3: atan_lut = 32'h051111D4;
      5'd4: atan_lut = 32'h028B0D43;  5'd5: atan_lut = 32'h0145D7E1;
      5'd6: atan_lut = 32'h00A2F61E;  5'd7: atan_lut = 32'h00517C55;
      5'd8: atan_lut = 32'h0028BE53;  5'd9: atan_lut = 32'h00145F2F;
      5'd10: atan_lut = 32'h000A2F98; 5'd11: atan_lut = 32'h000517CC;
      5'd12: atan_lut = 32'h00028BE6; 5'd13: atan_lut = 32'h000145F3;
      5'd14: atan_lut = 32'h0000A2F9; 5'd15: atan_lut = 32'h0000517C;
      5'd16: atan_lut = 32'h000028BE; 5'd17: atan_lut = 32'h0000145F;
      5'd18: atan_lut = 32'h00000A2F; 5'd19: atan_lut = 32'h00000517;
      5'd20: atan_lut = 32'h0000028B; 5'd21: atan_lut = 32'h00000145;
      5'd22: atan_lut = 32'h000000A2; 5'd23: atan_lut = 32'h00000051;
      default: atan_lut = 32'h0;
    endcase
  endfunction

endpackage

// ===== hdl/psc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_in_if / psc_out_if
// Valid/ready channels carrying input and result beats.
// ----------------------------------------------------------------------------
interface psc_in_if import psc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psc_out_if import psc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/point_seek_pd_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_seek_pd_controller_unit
// Distance/bearing CORDIC and two PD loops driving toward a target pose.
//
//  channel | dir | content
//  in_if   | in  | op, pos_x, pos_y, heading
//  out_if  | out | bearing, move_speed, rot_speed, status
//  apb     | in  | six config registers at 4*i
//
// A tick beat runs the CORDIC rotations and then six multiplies on the shared
// shift-add multiplier (distance gain, two terms per PD loop, rotation
// fade) before its result. Start, finished, timed-out and settled beats
// stop after the distance multiply. Reset restores register defaults and
// clears controller state. A result waits in the output register; the
// next beat is taken once it has been delivered.
// ----------------------------------------------------------------------------
module point_seek_pd_controller_unit import psc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  psc_in_if.sink      in_if,
  psc_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  typedef enum logic [3:0] {
    StIdle, StCordic, StMag, StMagW, StMove, StMoveW, StRot, StRotW,
    StFade, StFadeW, StOut
  } state_e;

  state_e state_q;

  logic [16:0] tx_q, ty_q, mmove_q, mrot_q;
  logic [15:0] thd_q, tmo_q;

  logic [23:0] pdist_q;
  logic [16:0] perr_q;
  logic [CntW-1:0] settle_q;
  logic [15:0] elapsed_q;
  logic        fin_q;

  in_beat_t    in_q;
  out_beat_t   res_q;
  logic        ovalid_q;

  logic signed [28:0] x_q, y_q;
  logic [31:0] z_q;
  logic [StepW-1:0] step_q;
  logic        zero_q;
  logic [23:0] dist_q;
  logic signed [17:0] e_q;
  logic [16:0] mv_q, rt_q;

  logic        mstart;
  logic [39:0] ma;
  logic [29:0] mb;
  logic        mdone;
  logic [69:0] mp;

  psc_sermul u_mul (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(mstart), .a_i(ma), .b_i(mb),
    .done_o(mdone), .p_o(mp)
  );

  wire cfg_wr = psel && penable && pwrite;
  wire [2:0] cfg_idx = paddr[4:2];
  assign pready = 1'b1;

  always_comb begin
    case (cfg_idx)
      RegTargetX:  prdata = {15'd0, tx_q};
      RegTargetY:  prdata = {15'd0, ty_q};
      RegTargetHd: prdata = {16'd0, thd_q};
      RegMaxMove:  prdata = {15'd0, mmove_q};
      RegMaxRot:   prdata = {15'd0, mrot_q};
      RegTimeout:  prdata = {16'd0, tmo_q};
      default:     prdata = '0;
    endcase
  end

  assign in_if.ready  = (state_q == StIdle) && !ovalid_q;
  assign out_if.valid = ovalid_q;
  assign out_if.data  = res_q;

  wire signed [17:0] dx = $signed({tx_q[16], tx_q}) - $signed({in_if.data.pos_x[16],
                          in_if.data.pos_x});
  wire signed [17:0] dy = $signed({ty_q[16], ty_q}) - $signed({in_if.data.pos_y[16],
                          in_if.data.pos_y});

  wire signed [28:0] xs = x_q >>> step_q;
  wire signed [28:0] ys = y_q >>> step_q;
  wire [31:0] at = atan_lut(5'(step_q));

  // heading error
  wire [15:0] d16 = thd_q - in_q.heading;
  wire [15:0] ae0 = d16[15] ? (16'd0 - d16) : d16;
  wire        wrapz = (17'd32768 - {1'b0, ae0}) <= {1'b0, Ang3Deg};
  wire signed [17:0] e_c = wrapz ? 18'sd0 : $signed({{2{d16[15]}}, d16});
  wire [15:0] ae = wrapz ? 16'd0 : ae0;

  wire [16:0] mlim = (mmove_q > SpeedOne) ? SpeedOne : mmove_q;
  wire [16:0] rlim = (mrot_q > SpeedOne) ? SpeedOne : mrot_q;

  // PD sums (pre-multiplied via the serial unit one term at a time is slow;
  // the coefficient terms are formed as a*K + delta*K2 using two products)
  logic signed [40:0] psum_q;
  logic        phase_q;

  wire signed [25:0] ddist = $signed({2'b0, dist_q}) - $signed({2'b0, pdist_q});
  wire signed [18:0] derr  = $signed({e_q[17], e_q}) - $signed({{2{perr_q[16]}}, perr_q});

  function automatic logic [16:0] clip(input logic signed [40:0] s, input logic [16:0] l);
    logic [40:0] a;
    logic [32:0] sh;
    logic [16:0] v;
    a  = s[40] ? 41'(-s) : 41'(s);
    sh = a[40:8];
    v  = (sh > 33'(SpeedOne)) ? SpeedOne : sh[16:0];
    clip = (v < l) ? v : l;
  endfunction

  wire [25:0] ad = ddist[25] ? 26'(-ddist) : 26'(ddist);
  wire [18:0] aer = derr[18] ? 19'(-derr) : 19'(derr);
  wire [17:0] aee = e_q[17] ? 18'(-e_q) : 18'(e_q);

  // fade scale dist*128/5 by reciprocal multiply, exact below 2560
  logic [16:0] fscale;
  logic [31:0] fprod;
  assign fprod = {20'd0, dist_q[11:0]} * 32'd838861;
  always_comb begin
    if (dist_q >= 24'd2560) fscale = SpeedOne;
    else if (dist_q < 24'd512) fscale = ScaleMin;
    else fscale = fprod[31:15];
  end

  always_comb begin
    mstart = 1'b0;
    ma = '0;
    mb = '0;
    case (state_q)
      StMag: begin
        mstart = 1'b1; ma = {11'd0, x_q}; mb = CordicGain;
      end
      StMove: begin
        mstart = 1'b1;
        ma = phase_q ? {14'd0, ad} : {16'd0, dist_q};
        mb = {16'd0, phase_q ? KdDist : KpDist};
      end
      StRot: begin
        mstart = 1'b1;
        ma = phase_q ? {21'd0, aer} : {22'd0, aee};
        mb = {16'd0, phase_q ? KdHead : KpHead};
      end
      StFade: begin
        mstart = 1'b1; ma = {23'd0, rt_q};
        mb = {13'd0, fscale};
      end
      default: ;
    endcase
  end

  wire signed [40:0] prod = $signed({1'b0, mp[39:0]});
  wire negt = (state_q == StMoveW) ? (phase_q ? ddist[25] : 1'b0)
                                   : (phase_q ? derr[18] : e_q[17]);
  wire signed [40:0] term = negt ? -prod : prod;
  wire signed [40:0] nsum = phase_q ? (psum_q + term) : term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      ovalid_q  <= 1'b0;
      tx_q      <= '0;
      ty_q      <= '0;
      thd_q     <= '0;
      mmove_q   <= SpeedOne;
      mrot_q    <= SpeedOne;
      tmo_q     <= 16'd100;
      pdist_q   <= '0;
      perr_q    <= '0;
      settle_q  <= '0;
      elapsed_q <= '0;
      fin_q     <= 1'b0;
      phase_q   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          RegTargetX:  tx_q    <= pwdata[16:0];
          RegTargetY:  ty_q    <= pwdata[16:0];
          RegTargetHd: thd_q   <= pwdata[15:0];
          RegMaxMove:  mmove_q <= pwdata[16:0];
          RegMaxRot:   mrot_q  <= pwdata[16:0];
          RegTimeout:  tmo_q   <= pwdata[15:0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) ovalid_q <= 1'b0;
      case (state_q)
        StIdle: if (in_if.valid && in_if.ready) begin
          in_q   <= in_if.data;
          zero_q <= (dx == 0) && (dy == 0);
          step_q <= '0;
          if (dx < 0) begin
            x_q <= -(29'(dx) <<< 8); y_q <= -(29'(dy) <<< 8); z_q <= 32'h80000000;
          end else begin
            x_q <= 29'(dx) <<< 8; y_q <= 29'(dy) <<< 8; z_q <= '0;
          end
          state_q <= StCordic;
        end
        StCordic: begin
          if (y_q >= 0) begin
            x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + at;
          end else begin
            x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - at;
          end
          step_q <= step_q + 1'b1;
          if (32'(step_q) == NumSteps - 1) state_q <= StMag;
        end
        StMag: begin
          res_q.bearing    <= zero_q ? 16'd0 : 16'((z_q + 32'h8000) >> 16);
          res_q.move_speed <= '0;
          res_q.rot_speed  <= '0;
          res_q.status     <= StatRun;
          if (x_q < 0) x_q <= '0;
          state_q <= StMagW;
        end
        StMagW: if (mdone) begin
          if (zero_q) dist_q <= '0;
          else if (mp[69:38] > 32'hFFFFFF) dist_q <= 24'hFFFFFF;
          else dist_q <= mp[61:38];
          e_q <= e_c;
          if (in_q.op == OpStart) begin
            pdist_q <= '0; perr_q <= '0; settle_q <= '0; elapsed_q <= '0;
            fin_q <= 1'b0; state_q <= StOut;
          end else if (fin_q) begin
            res_q.status <= (32'(settle_q) >= SettleTicks) ? StatSettled : StatTimeout;
            state_q <= StOut;
          end else if (elapsed_q >= tmo_q) begin
            fin_q <= 1'b1; res_q.status <= StatTimeout; state_q <= StOut;
          end else begin
            if (elapsed_q != 16'hFFFF) elapsed_q <= elapsed_q + 16'd1;
            phase_q <= 1'b0;
            state_q <= StMove;
            if (((zero_q ? 24'd0 : (mp[69:38] > 32'hFFFFFF ? 24'hFFFFFF : mp[61:38]))
                 <= PosTol) && (ae <= Ang3Deg)) begin
              if (32'(settle_q) + 1 >= SettleTicks) begin
                settle_q <= CntW'(SettleTicks);
                fin_q <= 1'b1; res_q.status <= StatSettled; state_q <= StOut;
              end else begin
                settle_q <= settle_q + 1'b1;
              end
            end else begin
              settle_q <= '0;
            end
          end
        end
        StMove: state_q <= StMoveW;
        StMoveW: if (mdone) begin
          psum_q <= nsum;
          if (phase_q) begin
            mv_q <= clip(nsum, mlim); pdist_q <= dist_q; phase_q <= 1'b0;
            state_q <= StRot;
          end else begin
            phase_q <= 1'b1; state_q <= StMove;
          end
        end
        StRot: state_q <= StRotW;
        StRotW: if (mdone) begin
          psum_q <= nsum;
          if (phase_q) begin
            rt_q <= (aee <= 18'(Ang1p5)) ? 17'd0 : clip(nsum, rlim);
            perr_q <= e_q[16:0]; phase_q <= 1'b0;
            state_q <= StFade;
          end else begin
            phase_q <= 1'b1; state_q <= StRot;
          end
        end
        StFade: state_q <= StFadeW;
        StFadeW: if (mdone) begin
          res_q.move_speed <= mv_q;
          res_q.rot_speed  <= mp[32:16];
          state_q <= StOut;
        end
        StOut: begin
          ovalid_q <= 1'b1;
          state_q  <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ===== hdl/psc_sermul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_sermul
// Shift-add multiplier, one multiplier bit per cycle: 40-bit unsigned a
// times 30-bit unsigned b, 70-bit product.
// ----------------------------------------------------------------------------
module psc_sermul import psc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [39:0] a_i,
  input  logic [29:0] b_i,
  output logic        done_o,
  output logic [69:0] p_o
);
  logic [69:0] acc_q;
  logic [69:0] a_q;
  logic [29:0] b_q;
  logic [4:0]  cnt_q;
  logic        busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        acc_q  <= '0;
        a_q    <= {30'd0, a_i};
        b_q    <= b_i;
      end else if (busy_q) begin
        if (b_q[0]) begin
          acc_q <= acc_q + a_q;
        end
        a_q   <= a_q << 1;
        b_q   <= b_q >> 1;
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd29) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assign p_o = acc_q;
endmodule
